// ===== hw/rtl/vpe_pkg.sv =====
// Shared types, widths and helpers for the Verlet point and edge block.
// No dependencies.
`timescale 1ns / 1ps
package vpe_pkg;

  localparam int POS_W   = 24;          // Q15.8 coordinate
  localparam int IDX_W   = 6;
  localparam int LEN_W   = 23;
  localparam int CMD_W   = 2;
  localparam int WIDE_W  = 28;          // headroom for sums before saturation
  localparam int DIF_W   = POS_W + 1;   // coordinate difference
  localparam int MUL_W   = 25;          // serial multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ROOT_W  = PROD_W / 2;
  localparam int DEN_W   = ROOT_W + 1;  // 2*d
  localparam int TMAG_W  = 26;          // kept magnitude of the correction
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 1;
  localparam int DEF_MAX_POINTS = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOXED   = 1'd1;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INTEG = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELAX = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [DIF_W-1:0]  dif_t;

  localparam wide_t POS_MIN   = -wide_t'(8388608);
  localparam wide_t POS_MAX   = wide_t'(8388607);
  localparam wide_t GRAV_STEP = wide_t'(64);     // 0.25 px
  localparam wide_t BOX_X_MAX = wide_t'(204800); // 800.0 px
  localparam wide_t BOX_Y_MAX = wide_t'(153600); // 600.0 px

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    pos_t             x_in;
    pos_t             y_in;
    logic [LEN_W-1:0] rest_length;
    logic             end_of_pass;
  } vpe_item_t;

  typedef struct packed {
    pos_t x_out;
    pos_t y_out;
    logic pass_done;
  } vpe_result_t;

  typedef struct packed {
    pos_t cx;
    pos_t cy;
    pos_t px;
    pos_t py;
  } vpe_point_t;

  function automatic pos_t sat_pos(input wide_t v);
    if (v < POS_MIN) return POS_MIN[POS_W-1:0];
    if (v > POS_MAX) return POS_MAX[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  function automatic pos_t clamp_pos(input wide_t v, input logic boxed, input wide_t hi);
    if (!boxed) return sat_pos(v);
    if (v < 0) return '0;
    if (v > hi) return hi[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/vpe_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on vpe_pkg.
`timescale 1ns / 1ps
module vpe_mul import vpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod,
  output logic              done
);
  localparam int CNT_W = $clog2(MUL_W);

  logic [MUL_W:0]     hi;
  logic [MUL_W-1:0]   lo;
  logic [MUL_W-1:0]   mcand;
  logic [CNT_W-1:0]   cnt;
  logic               run;
  logic [MUL_W:0]     sum;

  assign sum  = lo[0] ? (hi + {1'b0, mcand}) : hi;
  assign prod = {hi[MUL_W-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        cnt   <= '0;
        hi    <= '0;
        lo    <= op_b;
        mcand <= op_a;
      end else if (run) begin
        hi <= {1'b0, sum[MUL_W:1]};
        lo <= {sum[0], lo[MUL_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/vpe_sqrt.sv =====
// Bit-serial restoring integer square root, one root bit per cycle.
// Depends on vpe_pkg.
`timescale 1ns / 1ps
module vpe_sqrt import vpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [PROD_W-1:0] radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);
  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 3;

  logic [PROD_W-1:0] rad;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [REM_W-1:0]  rsh;
  logic [REM_W-1:0]  trial;

  assign rsh   = {rem[REM_W-3:0], rad[PROD_W-1 -: 2]};
  assign trial = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (run) begin
        rad <= {rad[PROD_W-3:0], 2'b00};
        if (rsh >= trial) begin
          rem  <= rsh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rsh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/vpe_div.sv =====
// Bit-serial restoring divider, unsigned, one quotient bit per cycle.
// Depends on vpe_pkg.
`timescale 1ns / 1ps
module vpe_div import vpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [PROD_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic [PROD_W-1:0] quo,
  output logic              done
);
  localparam int CNT_W = $clog2(PROD_W);

  logic [DEN_W-1:0] dv;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   rsh;
  logic [CNT_W-1:0] cnt;
  logic             run;

  // quo shifts the dividend out at the top and the quotient in at the bottom
  assign rsh = {rem[DEN_W-1:0], quo[PROD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
        quo <= num;
        dv  <= den;
        rem <= '0;
      end else if (run) begin
        if (rsh >= {1'b0, dv}) begin
          rem <= rsh - {1'b0, dv};
          quo <= {quo[PROD_W-2:0], 1'b1};
        end else begin
          rem <= rsh;
          quo <= {quo[PROD_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(PROD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/verlet_point_and_edge_relax.sv =====
// Top level: point store, command sequencer and the serial arithmetic units.
// Depends on vpe_pkg, vpe_mul, vpe_sqrt, vpe_div.
`timescale 1ns / 1ps
// Usage
//   A command transaction is taken at a clock edge with start high and busy low.
//   item carries command, indexes, load position, rest length and end_of_pass.
//   A result is shown on result for exactly one cycle with done high; the
//   receiver cannot stall it, so it must take every done cycle.
//   Read always answers; load, integrate and relax answer only when end_of_pass
//   is set (pass_done = 1, positions 0). Out-of-range indexes do nothing, and a
//   read of one answers zero.
// Sequence (busy while not idle; the result follows the last state):
//   load      - never busy; its result, if any, comes in the next cycle.
//   read      - RD_A, then WAIT_A (registered memory read).
//   integrate - RD_A (read), then WAIT_A (update and write back).
//   relax     - three reads, two serial squares, the serial root, one prep
//               step, then per axis a serial multiply and a serial divide,
//               then two writes; a zero root ends it after the root. The
//               divides are the longest part.
// Reset clears the sequencer and sets gravity_on and boxed_on to 1; point
// contents are undefined until loaded. cfg_we writes a register at any edge.
module verlet_point_and_edge_relax import vpe_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  vpe_item_t            item,
  output logic                 done,
  output vpe_result_t          result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);
  localparam int ADDR_W = $clog2(MAX_POINTS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_WAIT_A, S_WAIT_B, S_MXX, S_MYY, S_SQRT, S_PREP,
    S_MTX, S_DTX, S_MTY, S_DTY, S_WR_A, S_WR_B
  } state_t;

  state_t state;

  logic gravity_on, boxed_on;

  // latched transaction
  logic [CMD_W-1:0]  cmd_q;
  logic [ADDR_W-1:0] a_q, b_q;
  logic [LEN_W-1:0]  len_q;
  logic              eop_q;

  // point store
  vpe_point_t        mem [MAX_POINTS];
  vpe_point_t        rdata, wdata;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              we;

  // relax datapath
  vpe_point_t        pa, pb;
  dif_t              dx, dy;
  logic [PROD_W-1:0] sqx;
  logic [ROOT_W-1:0] d_q;
  logic [MUL_W-1:0]  diff_mag;
  logic              diff_neg;
  logic signed [TMAG_W:0] tx, ty;

  logic              mul_go, sqrt_go, div_go;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod, sq_sum, quo, div_num;
  logic [ROOT_W-1:0] root;
  logic              mul_done, sqrt_done, div_done;

  logic a_ok, b_ok;
  wide_t nx, ny;
  dif_t  dx_w, dy_w;
  logic signed [DIF_W:0] diff_w;
  logic signed [TMAG_W:0] t_w;
  logic  t_neg;

  assign a_ok = 32'(item.index_a) < MAX_POINTS;
  assign b_ok = 32'(item.index_b) < MAX_POINTS;
  assign busy = (state != S_IDLE);

  // ---------------- serial units ----------------
  vpe_mul  u_mul  (.clk, .rst, .go(mul_go), .op_a(mul_a), .op_b(mul_b),
                   .prod, .done(mul_done));
  vpe_sqrt u_sqrt (.clk, .rst, .go(sqrt_go), .radicand(sq_sum), .root,
                   .done(sqrt_done));
  vpe_div  u_div  (.clk, .rst, .go(div_go), .num(div_num), .den({d_q, 1'b0}),
                   .quo, .done(div_done));

  // ---------------- point store ----------------
  assign rd_addr = (state == S_WAIT_A) ? b_q : a_q;

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (we) mem[wr_addr] <= wdata;
  end

  // integrate: x' = 2x - prev, gravity on y, then clamp or saturate
  always_comb begin
    nx = (wide_t'(rdata.cx) <<< 1) - wide_t'(rdata.px);
    ny = (wide_t'(rdata.cy) <<< 1) - wide_t'(rdata.py) - (gravity_on ? GRAV_STEP : '0);
  end

  always_comb begin
    dx_w = dif_t'(wide_t'(pa.cx) - wide_t'(rdata.cx));
    dy_w = dif_t'(wide_t'(pa.cy) - wide_t'(rdata.cy));
    diff_w = $signed({3'b000, len_q}) - $signed({1'b0, root});
  end

  // signed correction from the divider magnitude; truncation toward zero
  always_comb begin
    t_neg = (state == S_DTX ? dx[DIF_W-1] : dy[DIF_W-1]) ^ diff_neg;
    t_w   = t_neg ? -$signed({1'b0, quo[TMAG_W-1:0]}) : $signed({1'b0, quo[TMAG_W-1:0]});
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = a_q;
    wdata   = pa;
    case (state)
      S_IDLE: begin
        we      = start && (item.command == CMD_LOAD) && a_ok;
        wr_addr = ADDR_W'(item.index_a);
        wdata   = '{cx: item.x_in, cy: item.y_in, px: item.x_in, py: item.y_in};
      end
      S_WAIT_A: begin
        we    = (cmd_q == CMD_INTEG);
        wdata = '{cx: clamp_pos(nx, boxed_on, BOX_X_MAX),
                  cy: clamp_pos(ny, boxed_on, BOX_Y_MAX),
                  px: rdata.cx, py: rdata.cy};
      end
      S_WR_A: begin
        we    = 1'b1;
        wdata = '{cx: sat_pos(wide_t'(pa.cx) + wide_t'(tx)),
                  cy: sat_pos(wide_t'(pa.cy) + wide_t'(ty)),
                  px: pa.px, py: pa.py};
      end
      S_WR_B: begin
        we      = 1'b1;
        wr_addr = b_q;
        wdata   = '{cx: sat_pos(wide_t'(pb.cx) - wide_t'(tx)),
                    cy: sat_pos(wide_t'(pb.cy) - wide_t'(ty)),
                    px: pb.px, py: pb.py};
      end
      default: ;
    endcase
  end

  // ---------------- config registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_on <= 1'b1;
      boxed_on   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAVITY: gravity_on <= cfg_data[0];
        CFG_BOXED:   boxed_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      mul_go  <= 1'b0;
      sqrt_go <= 1'b0;
      div_go  <= 1'b0;
    end else begin
      done    <= 1'b0;
      mul_go  <= 1'b0;
      sqrt_go <= 1'b0;
      div_go  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q  <= item.command;
            a_q    <= ADDR_W'(item.index_a);
            b_q    <= ADDR_W'(item.index_b);
            len_q  <= item.rest_length;
            eop_q  <= item.end_of_pass;
            result <= '{x_out: '0, y_out: '0, pass_done: item.end_of_pass};
            case (item.command)
              CMD_INTEG: begin
                if (a_ok) state <= S_RD_A;
                else done <= item.end_of_pass;
              end
              CMD_RELAX: begin
                if (a_ok && b_ok) state <= S_RD_A;
                else done <= item.end_of_pass;
              end
              CMD_READ: begin
                if (a_ok) state <= S_RD_A;
                else done <= 1'b1;
              end
              default: done <= item.end_of_pass;
            endcase
          end
        end
        S_RD_A: state <= S_WAIT_A;
        S_WAIT_A: begin
          pa <= rdata;
          case (cmd_q)
            CMD_READ: begin
              result <= '{x_out: rdata.cx, y_out: rdata.cy, pass_done: eop_q};
              done   <= 1'b1;
              state  <= S_IDLE;
            end
            CMD_RELAX: state <= S_WAIT_B;
            default: begin
              done  <= eop_q;
              state <= S_IDLE;
            end
          endcase
        end
        S_WAIT_B: begin
          pb     <= rdata;
          dx     <= dx_w;
          dy     <= dy_w;
          mul_a  <= MUL_W'(dx_w[DIF_W-1] ? -dx_w : dx_w);
          mul_b  <= MUL_W'(dx_w[DIF_W-1] ? -dx_w : dx_w);
          mul_go <= 1'b1;
          state  <= S_MXX;
        end
        S_MXX: begin
          if (mul_done) begin
            sqx    <= prod;
            mul_a  <= MUL_W'(dy[DIF_W-1] ? -dy : dy);
            mul_b  <= MUL_W'(dy[DIF_W-1] ? -dy : dy);
            mul_go <= 1'b1;
            state  <= S_MYY;
          end
        end
        S_MYY: begin
          if (mul_done) begin
            sq_sum  <= sqx + prod;
            sqrt_go <= 1'b1;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            d_q      <= root;
            diff_neg <= diff_w[DIF_W];
            diff_mag <= MUL_W'(diff_w[DIF_W] ? -diff_w : diff_w);
            if (root == '0) begin
              done  <= eop_q;
              state <= S_IDLE;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          mul_a  <= MUL_W'(dx[DIF_W-1] ? -dx : dx);
          mul_b  <= diff_mag;
          mul_go <= 1'b1;
          state  <= S_MTX;
        end
        S_MTX: begin
          if (mul_done) begin
            div_num <= prod;
            div_go  <= 1'b1;
            state   <= S_DTX;
          end
        end
        S_DTX: begin
          if (div_done) begin
            tx     <= t_w;
            mul_a  <= MUL_W'(dy[DIF_W-1] ? -dy : dy);
            mul_b  <= diff_mag;
            mul_go <= 1'b1;
            state  <= S_MTY;
          end
        end
        S_MTY: begin
          if (mul_done) begin
            div_num <= prod;
            div_go  <= 1'b1;
            state   <= S_DTY;
          end
        end
        S_DTY: begin
          if (div_done) begin
            ty    <= t_w;
            state <= S_WR_A;
          end
        end
        S_WR_A: state <= S_WR_B;
        S_WR_B: begin
          done  <= eop_q;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/tb_verlet_point_and_edge_relax.sv =====
// Testbench for verlet_point_and_edge_relax: random and directed command
// transactions checked against an in-bench point store. Depends on vpe_pkg.
`timescale 1ns / 1ps
module tb_verlet_point_and_edge_relax;
  import vpe_pkg::*;

  localparam int NPTS      = DEF_MAX_POINTS;
  localparam int WD_LIMIT  = 20000;  // cycles with no transaction at all
  localparam int SETTLE    = 400;    // wait after the queues run empty
  localparam longint XMAX  = 204800; // 800.0 px
  localparam longint YMAX  = 153600; // 600.0 px
  localparam longint PMIN  = -8388608;
  localparam longint PMAX  = 8388607;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  vpe_item_t   item = '0;
  logic        done;
  vpe_result_t result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRAVITY;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  verlet_point_and_edge_relax u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the point store and the two config bits.
  longint cur_x[NPTS], cur_y[NPTS], prv_x[NPTS], prv_y[NPTS];
  bit gravity_en = 1'b1;
  bit box_en     = 1'b1;

  vpe_item_t   pending_cmds[$];
  vpe_result_t expected_results[$];
  bit          loaded[NPTS];     // generator side: points with a load already queued
  int          sender_idle_pct = 0;
  int          errors = 0;
  int          quiet_cycles = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Floor square root, digit by digit.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Update the mirror for one accepted command and queue its answer, if any.
  function automatic void step_points(vpe_item_t it);
    int a = it.index_a;
    int b = it.index_b;
    longint nx, ny, dx, dy, d, len, tx, ty;
    vpe_result_t r = '0;
    case (it.command)
      CMD_LOAD: begin
        cur_x[a] = it.x_in; cur_y[a] = it.y_in;
        prv_x[a] = it.x_in; prv_y[a] = it.y_in;
      end
      CMD_INTEG: begin
        nx = 2 * cur_x[a] - prv_x[a];
        ny = 2 * cur_y[a] - prv_y[a];
        if (gravity_en) ny -= 64;
        prv_x[a] = cur_x[a];
        prv_y[a] = cur_y[a];
        cur_x[a] = box_en ? clip(nx, 0, XMAX) : clip(nx, PMIN, PMAX);
        cur_y[a] = box_en ? clip(ny, 0, YMAX) : clip(ny, PMIN, PMAX);
      end
      CMD_RELAX: begin
        dx  = cur_x[a] - cur_x[b];
        dy  = cur_y[a] - cur_y[b];
        d   = longint'(root_floor(longint'(dx * dx + dy * dy)));
        len = it.rest_length;
        // zero distance (same point or coincident points): no move
        if (d != 0) begin
          tx = (dx * (len - d)) / (2 * d);
          ty = (dy * (len - d)) / (2 * d);
          cur_x[a] = clip(cur_x[a] + tx, PMIN, PMAX);
          cur_y[a] = clip(cur_y[a] + ty, PMIN, PMAX);
          cur_x[b] = clip(cur_x[b] - tx, PMIN, PMAX);
          cur_y[b] = clip(cur_y[b] - ty, PMIN, PMAX);
        end
      end
      default: ;
    endcase
    if (it.command == CMD_READ) begin
      r.x_out = pos_t'(cur_x[a]);
      r.y_out = pos_t'(cur_y[a]);
    end
    r.pass_done = it.end_of_pass;
    if (it.command == CMD_READ || it.end_of_pass) expected_results.push_back(r);
  endfunction

  // Any command on a point never loaded becomes a load of its first point (index_a).
  function automatic void push_cmd(vpe_item_t it);
    if (it.command != CMD_LOAD &&
        (!loaded[it.index_a] || (it.command == CMD_RELAX && !loaded[it.index_b])))
      it.command = loaded[it.index_a] ? CMD_LOAD : CMD_LOAD;
    if (it.command == CMD_LOAD) loaded[it.index_a] = 1'b1;
    pending_cmds.push_back(it);
  endfunction

  function automatic vpe_item_t mk(logic [CMD_W-1:0] c, int a, int b,
                                   longint x, longint y, longint len, bit eop);
    vpe_item_t it;
    it.command = c; it.index_a = IDX_W'(a); it.index_b = IDX_W'(b);
    it.x_in = pos_t'(x); it.y_in = pos_t'(y);
    it.rest_length = len[LEN_W-1:0]; it.end_of_pass = eop;
    return it;
  endfunction

  // Mostly on-screen positions and modest lengths; some full-range noise.
  function automatic vpe_item_t random_cmd();
    vpe_item_t it;
    it.command = CMD_W'($urandom_range(3));
    // small working set so edges and reads land on loaded points
    it.index_a = IDX_W'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11));
    it.index_b = IDX_W'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11));
    if ($urandom_range(9) < 7) begin
      it.x_in = pos_t'($urandom_range(XMAX));
      it.y_in = pos_t'($urandom_range(YMAX));
    end else begin
      it.x_in = pos_t'($urandom);
      it.y_in = pos_t'($urandom);
    end
    it.rest_length = LEN_W'(($urandom_range(9) < 7) ? $urandom_range(40000) : $urandom);
    it.end_of_pass = ($urandom_range(5) == 0);
    return it;
  endfunction

  // Driver: presents pending commands, idling at random between transactions.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) step_points(item);
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          item  <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Monitor: every done cycle is a result transaction.
  always @(posedge clk) begin
    vpe_result_t w;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = expected_results.pop_front();
        if (result.x_out !== w.x_out) report("x_out", result.x_out, w.x_out);
        if (result.y_out !== w.y_out) report("y_out", result.y_out, w.y_out);
        if (result.pass_done !== w.pass_done)
          report("pass_done", result.pass_done, w.pass_done);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("tb_verlet_point_and_edge_relax: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(bit g, bit bx);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_GRAVITY; cfg_data <= g;
    @(posedge clk);
    gravity_en = g;
    cfg_index <= CFG_BOXED; cfg_data <= bx;
    @(posedge clk);
    box_en = bx;
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase_idle[4] = '{17, 57, 0, 0};
    bit phase_g[4]    = '{1, 0, 1, 0};
    bit phase_b[4]    = '{1, 0, 0, 1};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 4; p++) begin
      if (p > 0) write_cfg(phase_g[p], phase_b[p]);
      sender_idle_pct = phase_idle[p];
      if (p == 0) begin
        // field extremes, all commands, zero distance, box clamps
        push_cmd(mk(CMD_LOAD, 0, 0, PMAX, PMAX, 0, 1));
        push_cmd(mk(CMD_LOAD, 63, 0, PMIN, PMIN, 0, 0));
        push_cmd(mk(CMD_READ, 0, 63, 0, 0, 0, 0));
        push_cmd(mk(CMD_READ, 63, 0, 0, 0, 0, 1));
        push_cmd(mk(CMD_RELAX, 0, 63, 0, 0, 0, 1));
        push_cmd(mk(CMD_RELAX, 0, 63, 0, 0, 8388607, 0));
        push_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
        push_cmd(mk(CMD_RELAX, 0, 0, 0, 0, 100, 1));        // same point
        push_cmd(mk(CMD_LOAD, 1, 0, 1000, 1000, 0, 0));
        push_cmd(mk(CMD_LOAD, 2, 0, 1000, 1000, 0, 0));
        push_cmd(mk(CMD_RELAX, 1, 2, 0, 0, 5000, 0));      // coincident
        push_cmd(mk(CMD_LOAD, 3, 0, 0, 0, 0, 0));
        push_cmd(mk(CMD_RELAX, 3, 1, 0, 0, 256, 0));
        push_cmd(mk(CMD_INTEG, 3, 0, 0, 0, 0, 0));         // stays inside the box, no clamp
        push_cmd(mk(CMD_INTEG, 1, 0, 0, 0, 0, 1));
        push_cmd(mk(CMD_INTEG, 0, 0, 0, 0, 0, 0));         // clamps at 0
        push_cmd(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
        push_cmd(mk(CMD_READ, 3, 0, 0, 0, 0, 1));
        push_cmd(mk(CMD_READ, 1, 0, 0, 0, 0, 0));
      end
      if (p == 1) begin
        // unboxed: pull extreme points together, then keep one of them moving
        push_cmd(mk(CMD_LOAD, 4, 0, PMAX, PMIN, 0, 0));
        push_cmd(mk(CMD_LOAD, 5, 0, PMIN, PMAX, 0, 0));
        push_cmd(mk(CMD_RELAX, 4, 5, 0, 0, 0, 0));
        push_cmd(mk(CMD_INTEG, 4, 0, 0, 0, 0, 0));
        push_cmd(mk(CMD_INTEG, 4, 0, 0, 0, 0, 0));
        push_cmd(mk(CMD_READ, 4, 0, 0, 0, 0, 1));
      end
      for (int i = 0; i < 125; i++) push_cmd(random_cmd());
      drain();
    end
    if (errors == 0) $display("tb_verlet_point_and_edge_relax: clean");
    else $display("tb_verlet_point_and_edge_relax: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/vpe_pkg.sv
hw/rtl/vpe_mul.sv
hw/rtl/vpe_sqrt.sv
hw/rtl/vpe_div.sv
hw/rtl/verlet_point_and_edge_relax.sv
tb/tb_verlet_point_and_edge_relax.sv
